// File: rtl/process_sleep_scheduler_assert.svh
// assertion macros for the process sleep scheduler
// used by the top level; expects clk and rst_n in scope
`ifndef PROCESS_SLEEP_SCHEDULER_ASSERT_SVH
`define PROCESS_SLEEP_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define PSS_ASSERT_SAME(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("scheduler assertion failed");

// next-cycle implication
`define PSS_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("scheduler assertion failed");

`endif

// File: rtl/psched_pkg.sv
// shared types and constants of the process sleep scheduler
// no dependencies
`default_nettype none

package psched_pkg;

    localparam int DEF_MAX_SLOTS = 16;
    localparam logic [9:0] TPS_RESET = 10'd100;

    localparam logic [2:0] CMD_CREATE    = 3'd0;
    localparam logic [2:0] CMD_TERMINATE = 3'd1;
    localparam logic [2:0] CMD_SLEEP     = 3'd2;
    localparam logic [2:0] CMD_TICK      = 3'd3;
    localparam logic [2:0] CMD_YIELD     = 3'd4;
    localparam logic [2:0] CMD_QUERY     = 3'd5;
    localparam logic [2:0] CMD_FAULT     = 3'd6;

    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_NO_SLOT = 3'd1;
    localparam logic [2:0] STS_IMG_BAD = 3'd2;
    localparam logic [2:0] STS_KFAULT  = 3'd3;
    localparam logic [2:0] STS_NO_RUN  = 3'd4;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] seconds;
        logic        from_user_mode;
        logic        image_ok;
        logic [3:0]  target_id;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  created_id;
        logic [3:0]  current_process;
        logic        idle;
        logic [31:0] tick_count;
        logic [31:0] user_time;
        logic [31:0] system_time;
    } result_t;

    typedef struct packed {
        logic [31:0] user_ticks;
        logic [31:0] system_ticks;
        logic [31:0] sleep_start;
        logic [15:0] sleep_seconds;
    } rec_t;

endpackage

`default_nettype wire

// File: rtl/psched_obuf.sv
// one-entry output register between the scheduler core and the result stream
// depends on psched_pkg
`default_nettype none

module psched_obuf (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  psched_pkg::result_t     in_res,
    output logic                    out_valid,
    input  wire                     out_ready,
    output psched_pkg::result_t     out_res
);
    import psched_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= in_res;
        end
    end

endmodule

`default_nettype wire

// File: rtl/psched_core.sv
// scheduler sequencer with the link memory and the slot record memory
// depends on psched_pkg
`default_nettype none

module psched_core #(
    parameter int MAX_SLOTS = psched_pkg::DEF_MAX_SLOTS
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_we,
    input  wire [9:0]               cfg_wdata,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  psched_pkg::item_t       in_item,
    output logic                    res_valid,
    input  wire                     res_ready,
    output psched_pkg::result_t     res
);
    import psched_pkg::*;

    localparam int IDW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_POP   = 11'b000_0000_0010,
        S_SLP   = 11'b000_0000_0100,
        S_YLD   = 11'b000_0000_1000,
        S_TICK  = 11'b000_0001_0000,
        S_W_RD  = 11'b000_0010_0000,
        S_W_MUL = 11'b000_0100_0000,
        S_W_DEC = 11'b000_1000_0000,
        S_W_APP = 11'b001_0000_0000,
        S_FIN   = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } state_t;

    logic [IDW-1:0] link_mem [MAX_SLOTS];
    rec_t           rec_mem  [MAX_SLOTS];

    state_t         state_reg, state_next;
    logic [IDW-1:0] rhead_reg, rhead_next, rtail_reg, rtail_next;
    logic           rne_reg, rne_next;
    logic [IDW-1:0] shead_reg, shead_next, stail_reg, stail_next;
    logic           sne_reg, sne_next;
    logic [31:0]    tick_reg, tick_next;
    logic [IDW:0]   free_reg, free_next;
    logic [9:0]     tps_reg;
    logic [2:0]     status_reg, status_next;
    logic [IDW-1:0] created_reg, created_next;
    item_t          item_reg;
    logic [IDW-1:0] cur_reg, cur_next, prev_reg, prev_next, nxt_reg, nxt_next;
    logic           hasp_reg, hasp_next, last_reg, last_next;
    logic [25:0]    need_reg, need_next;
    logic [31:0]    elap_reg, elap_next;

    logic           link_we;
    logic [IDW-1:0] link_waddr, link_wdata, link_raddr, link_q;
    logic           rec_we;
    logic [IDW-1:0] rec_waddr, rec_raddr;
    rec_t           rec_wdata, rec_q;
    logic           last_w;

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_q <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        rec_q <= rec_mem[rec_raddr];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign last_w    = (cur_reg == stail_reg);

    always_comb
    begin
        res.status          = status_reg;
        res.created_id      = 4'(created_reg);
        res.current_process = rne_reg ? 4'(rhead_reg) : 4'd0;
        res.idle            = !rne_reg;
        res.tick_count      = tick_reg;
        res.user_time       = rne_reg ? rec_q.user_ticks : 32'd0;
        res.system_time     = rne_reg ? rec_q.system_ticks : 32'd0;
    end

    always_comb
    begin
        state_next   = state_reg;
        rhead_next   = rhead_reg;
        rtail_next   = rtail_reg;
        rne_next     = rne_reg;
        shead_next   = shead_reg;
        stail_next   = stail_reg;
        sne_next     = sne_reg;
        tick_next    = tick_reg;
        free_next    = free_reg;
        status_next  = status_reg;
        created_next = created_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        nxt_next     = nxt_reg;
        hasp_next    = hasp_reg;
        last_next    = last_reg;
        need_next    = need_reg;
        elap_next    = elap_reg;
        link_we      = 1'b0;
        link_waddr   = rtail_reg;
        link_wdata   = rhead_reg;
        link_raddr   = rhead_reg;
        rec_we       = 1'b0;
        rec_waddr    = rhead_reg;
        rec_wdata    = rec_q;
        rec_raddr    = rhead_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    status_next  = STS_OK;
                    created_next = '0;
                    state_next   = S_FIN;
                    case (in_item.command)
                        CMD_CREATE:
                        begin
                            if (free_reg == (IDW+1)'(MAX_SLOTS))
                            begin
                                status_next = STS_NO_SLOT;
                            end
                            else if (!in_item.image_ok)
                            begin
                                status_next = STS_IMG_BAD;
                            end
                            else
                            begin
                                rec_we       = 1'b1;
                                rec_waddr    = free_reg[IDW-1:0];
                                rec_wdata    = '0;
                                created_next = free_reg[IDW-1:0];
                                free_next    = free_reg + 1'b1;
                                if (rne_reg)
                                begin
                                    link_we    = 1'b1;
                                    link_waddr = rtail_reg;
                                    link_wdata = free_reg[IDW-1:0];
                                end
                                else
                                begin
                                    rhead_next = free_reg[IDW-1:0];
                                end
                                rtail_next = free_reg[IDW-1:0];
                                rne_next   = 1'b1;
                            end
                        end
                        CMD_TERMINATE, CMD_FAULT:
                        begin
                            if (in_item.command == CMD_FAULT && !in_item.from_user_mode)
                            begin
                                status_next = STS_KFAULT;
                            end
                            else if (!rne_reg)
                            begin
                                status_next = STS_NO_RUN;
                            end
                            else if (rhead_reg == rtail_reg)
                            begin
                                rne_next = 1'b0;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                        CMD_SLEEP:
                        begin
                            if (!rne_reg)
                            begin
                                status_next = STS_NO_RUN;
                            end
                            else
                            begin
                                state_next = S_SLP;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (rne_reg)
                            begin
                                state_next = S_TICK;
                            end
                            else
                            begin
                                tick_next = tick_reg + 32'd1;
                                if (sne_reg)
                                begin
                                    cur_next   = shead_reg;
                                    hasp_next  = 1'b0;
                                    state_next = S_W_RD;
                                end
                            end
                        end
                        CMD_YIELD:
                        begin
                            if (!rne_reg)
                            begin
                                status_next = STS_NO_RUN;
                            end
                            else if ((IDW+4)'(in_item.target_id) == (IDW+4)'(rhead_reg)
                                     && rhead_reg != rtail_reg)
                            begin
                                state_next = S_YLD;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (!rne_reg)
                            begin
                                status_next = STS_NO_RUN;
                            end
                        end
                        default:
                        begin
                            status_next = STS_OK;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                rhead_next = link_q;
                state_next = S_FIN;
            end
            S_SLP:
            begin
                rec_we                  = 1'b1;
                rec_waddr               = rhead_reg;
                rec_wdata.sleep_start   = tick_reg;
                rec_wdata.sleep_seconds = item_reg.seconds;
                if (rhead_reg == rtail_reg)
                begin
                    rne_next = 1'b0;
                end
                else
                begin
                    rhead_next = link_q;
                end
                if (sne_reg)
                begin
                    link_we    = 1'b1;
                    link_waddr = stail_reg;
                    link_wdata = rhead_reg;
                end
                else
                begin
                    shead_next = rhead_reg;
                end
                stail_next = rhead_reg;
                sne_next   = 1'b1;
                state_next = S_FIN;
            end
            S_YLD:
            begin
                rhead_next = link_q;
                link_we    = 1'b1;
                link_waddr = rtail_reg;
                link_wdata = rhead_reg;
                rtail_next = rhead_reg;
                state_next = S_FIN;
            end
            S_TICK:
            begin
                rec_we    = 1'b1;
                rec_waddr = rhead_reg;
                if (item_reg.from_user_mode)
                begin
                    rec_wdata.user_ticks = rec_q.user_ticks + 32'd1;
                end
                else
                begin
                    rec_wdata.system_ticks = rec_q.system_ticks + 32'd1;
                end
                tick_next = tick_reg + 32'd1;
                if (sne_reg)
                begin
                    cur_next   = shead_reg;
                    hasp_next  = 1'b0;
                    state_next = S_W_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_W_RD:
            begin
                link_raddr = cur_reg;
                rec_raddr  = cur_reg;
                state_next = S_W_MUL;
            end
            S_W_MUL:
            begin
                need_next  = 26'(rec_q.sleep_seconds) * 26'(tps_reg);
                elap_next  = tick_reg - rec_q.sleep_start;
                nxt_next   = link_q;
                state_next = S_W_DEC;
            end
            S_W_DEC:
            begin
                last_next = last_w;
                if (elap_reg >= 32'(need_reg))
                begin
                    if (last_w && !hasp_reg)
                    begin
                        sne_next = 1'b0;
                    end
                    else
                    begin
                        if (!hasp_reg)
                        begin
                            shead_next = nxt_reg;
                        end
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = prev_reg;
                            link_wdata = nxt_reg;
                        end
                        if (last_w)
                        begin
                            stail_next = prev_reg;
                        end
                    end
                    state_next = S_W_APP;
                end
                else
                begin
                    prev_next = cur_reg;
                    hasp_next = 1'b1;
                    if (last_w)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cur_next   = nxt_reg;
                        state_next = S_W_RD;
                    end
                end
            end
            S_W_APP:
            begin
                if (rne_reg)
                begin
                    link_we    = 1'b1;
                    link_waddr = rtail_reg;
                    link_wdata = cur_reg;
                end
                else
                begin
                    rhead_next = cur_reg;
                end
                rtail_next = cur_reg;
                rne_next   = 1'b1;
                if (last_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cur_next   = nxt_reg;
                    state_next = S_W_RD;
                end
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rhead_reg <= '0;
            rtail_reg <= '0;
            rne_reg   <= 1'b0;
            shead_reg <= '0;
            stail_reg <= '0;
            sne_reg   <= 1'b0;
            tick_reg  <= '0;
            free_reg  <= '0;
            tps_reg   <= TPS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            rhead_reg <= rhead_next;
            rtail_reg <= rtail_next;
            rne_reg   <= rne_next;
            shead_reg <= shead_next;
            stail_reg <= stail_next;
            sne_reg   <= sne_next;
            tick_reg  <= tick_next;
            free_reg  <= free_next;
            if (cfg_we)
            begin
                tps_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        created_reg <= created_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        nxt_reg     <= nxt_next;
        hasp_reg    <= hasp_next;
        last_reg    <= last_next;
        need_reg    <= need_next;
        elap_reg    <= elap_next;
        if (in_valid && state_reg == S_IDLE)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/process_sleep_scheduler.sv
// top level of the process sleep scheduler: stream ports, core and output register
// depends on psched_pkg, psched_core, psched_obuf and process_sleep_scheduler_assert.svh
//
// channel     dir  width  fields
// s_axis      in   32     command, seconds, from_user_mode, image_ok, target_id
// m_axis      out  112    status, created_id, current_process, idle, tick_count,
//                         user_time, system_time
// cfg         in   10     ticks_per_second
//
// one command at a time: create, query, a non-rotating yield and the status-only
// cases finish directly; sleep, a rotating yield and a terminate or fault that
// leaves another slot ready pass S_SLP, S_YLD or S_POP; a tick charges the running slot,
// then walks the sleepers, bound by the single read port of the slot record memory
// reset clears lists, counters and the free-slot count; no memory clearing pass
// a result waits in the output register; the next command is taken meanwhile
`default_nettype none

module process_sleep_scheduler #(
    parameter int MAX_SLOTS = psched_pkg::DEF_MAX_SLOTS
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          cfg_we,
    input  wire  [9:0]   cfg_wdata,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // command, seconds, from_user_mode, image_ok, target_id, zero pad
    input  wire  [31:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // status, created_id, current_process, idle, tick_count, user_time,
    // system_time, zero pad
    output logic [111:0] m_axis_tdata
);
    import psched_pkg::*;

    item_t   item;
    result_t core_res, out_res;
    logic    core_valid, core_ready;

    always_comb
    begin
        item.command        = s_axis_tdata[2:0];
        item.seconds        = s_axis_tdata[18:3];
        item.from_user_mode = s_axis_tdata[19];
        item.image_ok       = s_axis_tdata[20];
        item.target_id      = s_axis_tdata[24:21];
    end

    psched_core #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (item),
        .res_valid (core_valid),
        .res_ready (core_ready),
        .res       (core_res)
    );

    psched_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (core_valid),
        .in_ready  (core_ready),
        .in_res    (core_res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {4'b0, out_res.system_time, out_res.user_time, out_res.tick_count,
                           out_res.idle, out_res.current_process, out_res.created_id,
                           out_res.status};

`include "process_sleep_scheduler_assert.svh"

    `PSS_ASSERT_NEXT(a_one_cmd, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `PSS_ASSERT_SAME(a_idle_clear, m_axis_tvalid && m_axis_tdata[11],
        m_axis_tdata[10:7] == 4'd0 && m_axis_tdata[107:44] == 64'd0)
    `PSS_ASSERT_SAME(a_status_range, m_axis_tvalid, m_axis_tdata[2:0] <= STS_NO_RUN)

endmodule

`default_nettype wire
